### rtl/core/sld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

	localparam int PORT_W = 2;
	localparam int PORT_SLOTS = 1 << PORT_W;
	localparam int BYTE_W = 8;
	localparam int LEN_W = 10;
	localparam int STATUS_W = 2;
	localparam int MASK_W = 4;

	localparam logic [BYTE_W-1:0] CODE_END = 8'hC0;
	localparam logic [BYTE_W-1:0] CODE_ESC = 8'hDB;
	localparam logic [BYTE_W-1:0] CODE_ESC_END = 8'hDC;
	localparam logic [BYTE_W-1:0] CODE_ESC_ESC = 8'hDD;

	localparam logic [STATUS_W-1:0] STATUS_GOOD = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_HANDLER = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		KIND_PLAIN,
		KIND_END,
		KIND_ESC,
		KIND_ESC_END,
		KIND_ESC_ESC
	} byte_kind_t;

	typedef struct packed {
		logic [PORT_W-1:0] port;
		logic [BYTE_W-1:0] rx_byte;
		byte_kind_t kind;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

endpackage

`default_nettype wire

### rtl/core/sld_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sld_front import sld_pkg::*; #(
	parameter int NUM_PORTS = 4
) (
	input  wire logic              byte_valid,
	output logic                   byte_ready,
	input  wire logic [PORT_W-1:0] port,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire queue_stat_t       qstat,
	output logic                   push,
	output item_t                  push_item
);

	logic port_ok;

	assign byte_ready = !qstat.full;
	assign port_ok = (32'(port) < NUM_PORTS);
	assign push = byte_valid && byte_ready && port_ok;

	always_comb begin
		push_item.port = port;
		push_item.rx_byte = rx_byte;
		case (rx_byte)
			CODE_END: push_item.kind = KIND_END;
			CODE_ESC: push_item.kind = KIND_ESC;
			CODE_ESC_END: push_item.kind = KIND_ESC_END;
			CODE_ESC_ESC: push_item.kind = KIND_ESC_ESC;
			default: push_item.kind = KIND_PLAIN;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/sld_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sld_queue import sld_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      head,
	output queue_stat_t qstat
);

	item_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign qstat.empty = (count_q == '0);
	assign qstat.full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

### rtl/core/sld_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sld_back import sld_pkg::*; #(
	parameter int FRAME_CAPACITY = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire item_t             head,
	input  wire queue_stat_t       qstat,
	output logic                   pop,
	input  wire logic [MASK_W-1:0] handler_mask,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output logic [PORT_W-1:0]      out_port,
	output logic                   is_frame_end,
	output logic [BYTE_W-1:0]      data_byte,
	output logic [LEN_W-1:0]       frame_length,
	output logic [STATUS_W-1:0]    frame_status,
	output logic                   bad_escape
);

	localparam int CNT_W = $clog2(FRAME_CAPACITY);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_CAPACITY - 1);

	logic [CNT_W-1:0] count_q [PORT_SLOTS];
	logic escape_q [PORT_SLOTS];
	logic overflow_q [PORT_SLOTS];
	logic valid_q;
	logic [PORT_W-1:0] port_q;
	logic end_q;
	logic [BYTE_W-1:0] data_q;
	logic [LEN_W-1:0] len_q;
	logic [STATUS_W-1:0] status_q;
	logic bad_q;

	logic [CNT_W-1:0] cnt;
	logic esc;
	logic ovf;
	logic [CNT_W-1:0] cnt_nxt;
	logic esc_nxt;
	logic ovf_nxt;
	logic store;
	logic [BYTE_W-1:0] store_byte;
	logic store_bad;
	logic emit;
	logic emit_end;
	logic [STATUS_W-1:0] emit_status;

	assign pop = !qstat.empty && (!valid_q || result_ready);
	assign cnt = count_q[head.port];
	assign esc = escape_q[head.port];
	assign ovf = overflow_q[head.port];

	always_comb begin
		cnt_nxt = cnt;
		esc_nxt = esc;
		ovf_nxt = ovf;
		store = 1'b0;
		store_byte = head.rx_byte;
		store_bad = 1'b0;
		emit = 1'b0;
		emit_end = 1'b0;
		emit_status = STATUS_GOOD;
		if (ovf) begin
			if (head.kind == KIND_END) begin
				emit = 1'b1;
				emit_end = 1'b1;
				emit_status = STATUS_OVERFLOW;
				cnt_nxt = '0;
				esc_nxt = 1'b0;
				ovf_nxt = 1'b0;
			end
		end else if (esc) begin
			esc_nxt = 1'b0;
			store = 1'b1;
			case (head.kind)
				KIND_ESC_END: store_byte = CODE_END;
				KIND_ESC_ESC: store_byte = CODE_ESC;
				default: store_bad = 1'b1;
			endcase
		end else begin
			case (head.kind)
				KIND_END: begin
					if (cnt != '0) begin
						emit = 1'b1;
						emit_end = 1'b1;
						emit_status = handler_mask[head.port] ? STATUS_GOOD
							: STATUS_NO_HANDLER;
						cnt_nxt = '0;
						esc_nxt = 1'b0;
						ovf_nxt = 1'b0;
					end
				end
				KIND_ESC: esc_nxt = 1'b1;
				default: store = 1'b1;
			endcase
		end
		if (store) begin
			if (cnt < CNT_LAST) begin
				cnt_nxt = cnt + 1'b1;
				emit = 1'b1;
			end else begin
				ovf_nxt = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORT_SLOTS; i++) begin
				count_q[i] <= '0;
				escape_q[i] <= 1'b0;
				overflow_q[i] <= 1'b0;
			end
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				count_q[head.port] <= cnt_nxt;
				escape_q[head.port] <= esc_nxt;
				overflow_q[head.port] <= ovf_nxt;
				valid_q <= emit;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			port_q <= head.port;
			end_q <= emit_end;
			data_q <= emit_end ? '0 : store_byte;
			len_q <= emit_end ? LEN_W'(cnt) : '0;
			status_q <= emit_status;
			bad_q <= emit_end ? 1'b0 : store_bad;
		end
	end

	assign result_valid = valid_q;
	assign out_port = port_q;
	assign is_frame_end = end_q;
	assign data_byte = data_q;
	assign frame_length = len_q;
	assign frame_status = status_q;
	assign bad_escape = bad_q;

endmodule

`default_nettype wire

### rtl/core/slip_receive_deframer.sv
// SLIP receive deframer for several serial ports.
// Each word on the byte channel (byte_valid, byte_ready, port, rx_byte) is one
// raw line byte and the port it arrived on. The result channel (result_valid,
// result_ready and the result fields) returns decoded data bytes at once and
// an end marker with length and status when a non-empty frame closes.
// The front classifies bytes into a four-entry queue; the back holds the
// per-port count, escape and overflow state and an output register.
// One word is taken every cycle while the queue is not full. The rate is set
// by the back, which retires one queue entry per cycle through a single read
// and update of the port state while its output register is free or taken.
// When the receiver stalls, the output register holds its word, the queue
// fills, and byte_ready drops only when the queue is full.
// Reset clears all port state, the queue and the handler mask; there is no
// clearing pass. The handler mask is written over the APB port at address 0.
`timescale 1ns / 1ps
`default_nettype none

module slip_receive_deframer import sld_pkg::*; #(
	parameter int NUM_PORTS = 4,
	parameter int FRAME_CAPACITY = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready,
	input  wire logic                byte_valid,
	output logic                     byte_ready,
	input  wire logic [PORT_W-1:0]   port,
	input  wire logic [BYTE_W-1:0]   rx_byte,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output logic [PORT_W-1:0]        out_port,
	output logic                     is_frame_end,
	output logic [BYTE_W-1:0]        data_byte,
	output logic [LEN_W-1:0]         frame_length,
	output logic [STATUS_W-1:0]      frame_status,
	output logic                     bad_escape
);

	localparam logic REG_HANDLER_MASK = 1'b0;

	logic [MASK_W-1:0] handler_mask_q;
	logic push;
	logic pop;
	item_t push_item;
	item_t head;
	queue_stat_t qstat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HANDLER_MASK) ? 32'(handler_mask_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handler_mask_q <= '0;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == REG_HANDLER_MASK) begin
			handler_mask_q <= pwdata[MASK_W-1:0];
		end
	end

	sld_front #(
		.NUM_PORTS(NUM_PORTS)
	) u_front (
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.port(port),
		.rx_byte(rx_byte),
		.qstat(qstat),
		.push(push),
		.push_item(push_item)
	);

	sld_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head(head),
		.qstat(qstat)
	);

	sld_back #(
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.qstat(qstat),
		.pop(pop),
		.handler_mask(handler_mask_q),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_port(out_port),
		.is_frame_end(is_frame_end),
		.data_byte(data_byte),
		.frame_length(frame_length),
		.frame_status(frame_status),
		.bad_escape(bad_escape)
	);

endmodule

`default_nettype wire

### tb/slip_receive_deframer_test.sv
`timescale 1ns / 1ps

module slip_receive_deframer_test;
	import sld_pkg::*;

	localparam int NUM_PORTS = 4;
	localparam int FRAME_CAPACITY = 1024;
	localparam int REG_HANDLER_MASK = 0;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 270;
	localparam int TX_IDLE [3] = '{16, 66, 0};
	localparam int RX_IDLE [3] = '{66, 16, 0};

	typedef struct packed {
		logic [PORT_W-1:0] port;
		logic is_end;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0] len;
		logic [STATUS_W-1:0] status;
		logic bad;
	} slip_result_t;

	typedef struct packed {
		logic [PORT_W-1:0] port;
		logic [BYTE_W-1:0] line;
		logic [10:0] reps;
		logic typed;
		logic gives;
		slip_result_t res;
	} dir_row_t;

	localparam dir_row_t DIRECTED [24] = '{
		'{2'd0, 8'h00, 11'd1, 1'b1, 1'b1, '{2'd0, 1'b0, 8'h00, 10'd0, STATUS_GOOD, 1'b0}},
		'{2'd0, 8'hFF, 11'd1, 1'b1, 1'b1, '{2'd0, 1'b0, 8'hFF, 10'd0, STATUS_GOOD, 1'b0}},
		'{2'd0, CODE_END, 11'd1, 1'b1, 1'b1, '{2'd0, 1'b1, 8'h00, 10'd2, STATUS_GOOD, 1'b0}},
		'{2'd0, CODE_END, 11'd1, 1'b1, 1'b0, '0},
		'{2'd1, CODE_ESC, 11'd1, 1'b1, 1'b0, '0},
		'{2'd1, CODE_ESC_END, 11'd1, 1'b1, 1'b1,
			'{2'd1, 1'b0, CODE_END, 10'd0, STATUS_GOOD, 1'b0}},
		'{2'd1, CODE_ESC, 11'd1, 1'b1, 1'b0, '0},
		'{2'd1, CODE_ESC_ESC, 11'd1, 1'b1, 1'b1,
			'{2'd1, 1'b0, CODE_ESC, 10'd0, STATUS_GOOD, 1'b0}},
		'{2'd1, CODE_ESC, 11'd1, 1'b1, 1'b0, '0},
		'{2'd1, 8'h41, 11'd1, 1'b1, 1'b1, '{2'd1, 1'b0, 8'h41, 10'd0, STATUS_GOOD, 1'b1}},
		'{2'd1, CODE_ESC, 11'd1, 1'b1, 1'b0, '0},
		'{2'd1, CODE_END, 11'd1, 1'b1, 1'b1,
			'{2'd1, 1'b0, CODE_END, 10'd0, STATUS_GOOD, 1'b1}},
		'{2'd1, CODE_ESC, 11'd1, 1'b1, 1'b0, '0},
		'{2'd1, CODE_ESC, 11'd1, 1'b1, 1'b1,
			'{2'd1, 1'b0, CODE_ESC, 10'd0, STATUS_GOOD, 1'b1}},
		'{2'd1, CODE_END, 11'd1, 1'b1, 1'b1,
			'{2'd1, 1'b1, 8'h00, 10'd5, STATUS_NO_HANDLER, 1'b0}},
		'{2'd2, 8'hAA, 11'd1, 1'b0, 1'b0, '0},
		'{2'd3, 8'h55, 11'd1, 1'b0, 1'b0, '0},
		'{2'd2, CODE_END, 11'd1, 1'b1, 1'b1, '{2'd2, 1'b1, 8'h00, 10'd1, STATUS_GOOD, 1'b0}},
		'{2'd3, 8'h3C, 11'd1022, 1'b0, 1'b0, '0},
		'{2'd3, CODE_ESC, 11'd1, 1'b1, 1'b0, '0},
		'{2'd3, CODE_ESC_ESC, 11'd1, 1'b1, 1'b0, '0},
		'{2'd3, CODE_ESC, 11'd1, 1'b1, 1'b0, '0},
		'{2'd3, CODE_END, 11'd1, 1'b1, 1'b1,
			'{2'd3, 1'b1, 8'h00, 10'd1023, STATUS_OVERFLOW, 1'b0}},
		'{2'd3, CODE_END, 11'd1, 1'b1, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic byte_valid = 1'b0;
	logic byte_ready;
	logic [PORT_W-1:0] port = '0;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [PORT_W-1:0] out_port;
	logic is_frame_end;
	logic [BYTE_W-1:0] data_byte;
	logic [LEN_W-1:0] frame_length;
	logic [STATUS_W-1:0] frame_status;
	logic bad_escape;

	slip_receive_deframer #(
		.NUM_PORTS(NUM_PORTS),
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.port(port),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_port(out_port),
		.is_frame_end(is_frame_end),
		.data_byte(data_byte),
		.frame_length(frame_length),
		.frame_status(frame_status),
		.bad_escape(bad_escape)
	);

	always #6 clk = ~clk;

	logic [MASK_W-1:0] handler_mask = '0;
	int frame_count [PORT_SLOTS];
	bit escape_seen [PORT_SLOTS];
	bit overflow_hit [PORT_SLOTS];
	slip_result_t due_results [$];

	bit use_table_result = 1'b0;
	bit table_gives;
	slip_result_t table_result;

	int mismatches = 0;
	int quiet_cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_request = 1'b0;

	int gen_left [PORT_SLOTS];
	bit gen_has_second [PORT_SLOTS];
	logic [BYTE_W-1:0] gen_second [PORT_SLOTS];

	task automatic report_mismatch(input string what, input int unsigned expv,
		input int unsigned gotv);
		$display("%0t mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, expv, gotv);
		mismatches++;
	endtask

	function automatic bit store_decoded(input logic [PORT_W-1:0] p,
		input logic [BYTE_W-1:0] b, input bit bad, inout slip_result_t r);
		if (frame_count[p] < FRAME_CAPACITY - 1) begin
			frame_count[p]++;
			r.data = b;
			r.bad = bad;
			return 1'b1;
		end
		overflow_hit[p] = 1'b1;
		return 1'b0;
	endfunction

	function automatic bit decode_line_byte(input logic [PORT_W-1:0] p,
		input logic [BYTE_W-1:0] c, output slip_result_t r);
		r = '0;
		r.port = p;
		if (p >= NUM_PORTS)
			return 1'b0;
		if (overflow_hit[p] || (!escape_seen[p] && c == CODE_END)) begin
			if (c != CODE_END || frame_count[p] == 0)
				return 1'b0;
			r.is_end = 1'b1;
			r.len = LEN_W'(frame_count[p]);
			if (overflow_hit[p])
				r.status = STATUS_OVERFLOW;
			else
				r.status = handler_mask[p] ? STATUS_GOOD : STATUS_NO_HANDLER;
			frame_count[p] = 0;
			escape_seen[p] = 1'b0;
			overflow_hit[p] = 1'b0;
			return 1'b1;
		end
		if (escape_seen[p]) begin
			escape_seen[p] = 1'b0;
			if (c == CODE_ESC_END)
				return store_decoded(p, CODE_END, 1'b0, r);
			if (c == CODE_ESC_ESC)
				return store_decoded(p, CODE_ESC, 1'b0, r);
			return store_decoded(p, c, 1'b1, r);
		end
		if (c == CODE_ESC) begin
			escape_seen[p] = 1'b1;
			return 1'b0;
		end
		return store_decoded(p, c, 1'b0, r);
	endfunction

	// Most words continue a well-formed frame; when noisy is set, a few are raw noise.
	function automatic logic [BYTE_W-1:0] next_line_byte(input logic [PORT_W-1:0] p,
		input bit noisy, output bit frame_done);
		logic [BYTE_W-1:0] b;
		frame_done = 1'b0;
		if (noisy && $urandom_range(19) == 0)
			return BYTE_W'($urandom_range(255));
		if (gen_has_second[p]) begin
			gen_has_second[p] = 1'b0;
			return gen_second[p];
		end
		if (gen_left[p] == 0) begin
			gen_left[p] = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(10);
			frame_done = 1'b1;
			return CODE_END;
		end
		gen_left[p]--;
		if ($urandom_range(6) == 0) begin
			gen_has_second[p] = 1'b1;
			case ($urandom_range(4))
				0, 1: gen_second[p] = CODE_ESC_END;
				2, 3: gen_second[p] = CODE_ESC_ESC;
				default: gen_second[p] = BYTE_W'($urandom_range(255));
			endcase
			return CODE_ESC;
		end
		b = BYTE_W'($urandom_range(255));
		if (b == CODE_END || b == CODE_ESC)
			b = b ^ 8'h01;
		return b;
	endfunction

	task automatic send_word(input logic [PORT_W-1:0] p, input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		port <= p;
		rx_byte <= b;
		do begin
			@(posedge clk);
		end while (!byte_ready);
		@(negedge clk);
	endtask

	task automatic write_mask(input logic [MASK_W-1:0] m);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'(4 * REG_HANDLER_MASK);
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		rd = prdata;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b1;
		pwdata <= 32'(m);
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (rd !== 32'(handler_mask))
			report_mismatch("handler_present_mask readback", handler_mask, rd);
		handler_mask = m;
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		slip_result_t predicted;
		slip_result_t due;
		bit gives;
		if (arst_n) begin
			if (byte_valid && byte_ready) begin
				gives = decode_line_byte(port, rx_byte, predicted);
				if (use_table_result) begin
					gives = table_gives;
					predicted = table_result;
				end
				if (gives)
					due_results.push_back(predicted);
			end
			if (result_valid && result_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result word on port", 0, out_port);
				end else begin
					due = due_results.pop_front();
					if (out_port !== due.port)
						report_mismatch("out_port", due.port, out_port);
					if (is_frame_end !== due.is_end)
						report_mismatch("is_frame_end", due.is_end, is_frame_end);
					if (data_byte !== due.data)
						report_mismatch("data_byte", due.data, data_byte);
					if (frame_length !== due.len)
						report_mismatch("frame_length", due.len, frame_length);
					if (frame_status !== due.status)
						report_mismatch("frame_status", due.status, frame_status);
					if (bad_escape !== due.bad)
						report_mismatch("bad_escape", due.bad, bad_escape);
				end
			end
			if ((byte_valid && byte_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("[slip_receive_deframer] ERROR");
		$finish;
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				result_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		logic [PORT_W-1:0] p;
		logic [BYTE_W-1:0] b;
		bit done;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_mask(4'b0101);

		for (int i = 0; i < 24; i++) begin
			use_table_result = DIRECTED[i].typed;
			table_gives = DIRECTED[i].gives;
			table_result = DIRECTED[i].res;
			for (int k = 0; k < DIRECTED[i].reps; k++)
				send_word(DIRECTED[i].port, DIRECTED[i].line);
		end
		use_table_result = 1'b0;

		for (int ph = 0; ph < 3; ph++) begin
			wait_drained();
			case (ph)
				0: write_mask(4'hF);
				1: write_mask(4'h0);
				default: write_mask(MASK_W'($urandom_range(1, 14)));
			endcase
			tx_idle_pct = TX_IDLE[ph];
			rx_idle_pct = RX_IDLE[ph];
			if (ph == 1) begin
				// One frame of at least FRAME_CAPACITY - 1 data bytes, which can overflow, sent without interleaving.
				p = PORT_W'($urandom_range(3));
				gen_left[p] = $urandom_range(FRAME_CAPACITY - 1, FRAME_CAPACITY + 36);
				do begin
					b = next_line_byte(p, 1'b0, done);
					send_word(p, b);
				end while (!done);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 0 && n == 60)
					hold_request = 1'b1;
				p = PORT_W'($urandom_range(3));
				b = next_line_byte(p, 1'b1, done);
				send_word(p, b);
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("[slip_receive_deframer] OK");
		else
			$display("[slip_receive_deframer] ERROR");
		$finish;
	end

endmodule
